// ===== rtl/hcb_pkg.sv =====
// shared types and constants for the histogram color bounds unit
package hcb_pkg;

    localparam int NUM_CH       = 3;
    localparam int COMP_W       = 8;
    localparam int THRESH_W     = 16;
    localparam int LOW_W        = 8;
    localparam int HIGH_W       = 9;
    localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd5;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPD,
        ST_SCAN,
        ST_DRAIN,
        ST_OUTPUT
    } state_t;

    typedef struct packed {
        logic pix_read;
        logic pix_write;
        logic sweep;
        logic scan;
        logic scan_init;
        logic result_load;
    } cmd_t;

    typedef struct packed {
        logic addr_last;
        logic last_pixel;
    } status_t;

endpackage

// ===== rtl/hcb_ram.sv =====
// generic single write port ram with registered read-first read
module hcb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/hcb_datapath.sv =====
// histogram memories, bin sweep counter, bound trackers and result registers
module hcb_datapath #(
    parameter int BINS        = 256,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  hcb_pkg::cmd_t                        cmd,
    output hcb_pkg::status_t                     status,
    input  logic                                 cfg_wr_en,
    input  logic [hcb_pkg::THRESH_W-1:0]         cfg_wr_data,
    input  logic [hcb_pkg::COMP_W-1:0]           pix [hcb_pkg::NUM_CH],
    input  logic                                 pix_last,
    output logic [hcb_pkg::LOW_W-1:0]            res_low [hcb_pkg::NUM_CH],
    output logic [hcb_pkg::HIGH_W-1:0]           res_high [hcb_pkg::NUM_CH]
);

    localparam int AW   = $clog2(BINS);
    localparam int CMPW = (COUNT_WIDTH > hcb_pkg::THRESH_W) ? COUNT_WIDTH : hcb_pkg::THRESH_W;

    function automatic logic [AW-1:0] bin_of(input logic [hcb_pkg::COMP_W-1:0] v);
        if (32'(v) >= BINS) begin
            return AW'(BINS - 1);
        end
        return AW'(v);
    endfunction

    logic [hcb_pkg::THRESH_W-1:0] thresh_reg;
    logic [AW-1:0]                addr_reg, addr_next;
    logic                         scan_vld_reg;
    logic [AW-1:0]                scan_idx_reg;
    logic                         last_reg;
    logic [AW-1:0]                bin_reg [hcb_pkg::NUM_CH];

    logic [AW-1:0]          rd_addr [hcb_pkg::NUM_CH];
    logic [AW-1:0]          wr_addr [hcb_pkg::NUM_CH];
    logic [COUNT_WIDTH-1:0] wr_data [hcb_pkg::NUM_CH];
    logic [COUNT_WIDTH-1:0] rd_data [hcb_pkg::NUM_CH];
    logic                   wr_en;
    logic                   qual [hcb_pkg::NUM_CH];

    logic          low_found_reg  [hcb_pkg::NUM_CH];
    logic [AW-1:0] low_reg        [hcb_pkg::NUM_CH];
    logic          high_found_reg [hcb_pkg::NUM_CH];
    logic [AW-1:0] high_reg       [hcb_pkg::NUM_CH];
    logic [hcb_pkg::LOW_W-1:0]  low_res_reg  [hcb_pkg::NUM_CH];
    logic [hcb_pkg::HIGH_W-1:0] high_res_reg [hcb_pkg::NUM_CH];
    logic [hcb_pkg::LOW_W-1:0]  low_out  [hcb_pkg::NUM_CH];
    logic [hcb_pkg::HIGH_W-1:0] high_out [hcb_pkg::NUM_CH];

    assign wr_en = cmd.pix_write || cmd.sweep;

    genvar g;
    generate
        for (g = 0; g < hcb_pkg::NUM_CH; g++) begin : g_ch
            logic [AW+hcb_pkg::LOW_W-1:0]  low_wide;
            logic [AW+hcb_pkg::HIGH_W-1:0] high_wide;

            always_comb begin
                rd_addr[g] = cmd.pix_read ? bin_of(pix[g]) : addr_reg;
                wr_addr[g] = cmd.sweep ? addr_reg : bin_reg[g];
                if (cmd.sweep) begin
                    wr_data[g] = '0;
                end else if (rd_data[g] == {COUNT_WIDTH{1'b1}}) begin
                    // saturated bin stays at top count
                    wr_data[g] = rd_data[g];
                end else begin
                    wr_data[g] = rd_data[g] + COUNT_WIDTH'(1);
                end
                qual[g] = CMPW'(rd_data[g]) >= CMPW'(thresh_reg);

                low_wide  = {{hcb_pkg::LOW_W{1'b0}},
                             (low_found_reg[g] ? low_reg[g] : AW'(BINS - 1))};
                high_wide = {{hcb_pkg::HIGH_W{1'b0}}, high_reg[g]};
                low_out[g]  = low_wide[hcb_pkg::LOW_W-1:0];
                high_out[g] = high_found_reg[g] ? high_wide[hcb_pkg::HIGH_W-1:0] : '1;
            end

            hcb_ram #(
                .WIDTH (COUNT_WIDTH),
                .DEPTH (BINS)
            ) u_hist (
                .aclk    (aclk),
                .wr_en   (wr_en),
                .wr_addr (wr_addr[g]),
                .wr_data (wr_data[g]),
                .rd_addr (rd_addr[g]),
                .rd_data (rd_data[g])
            );

            assign res_low[g]  = low_res_reg[g];
            assign res_high[g] = high_res_reg[g];
        end
    endgenerate

    always_comb begin
        if (cmd.sweep) begin
            addr_next = (addr_reg == AW'(BINS - 1)) ? '0 : addr_reg + AW'(1);
        end else begin
            addr_next = addr_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg   <= hcb_pkg::THRESH_RESET;
            addr_reg     <= '0;
            scan_vld_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                thresh_reg <= cfg_wr_data;
            end
            addr_reg     <= addr_next;
            scan_vld_reg <= cmd.sweep && cmd.scan;
        end
    end

    always_ff @(posedge aclk) begin
        scan_idx_reg <= addr_reg;
        if (cmd.pix_read) begin
            last_reg <= pix_last;
            for (int c = 0; c < hcb_pkg::NUM_CH; c++) begin
                bin_reg[c] <= bin_of(pix[c]);
            end
        end
        for (int c = 0; c < hcb_pkg::NUM_CH; c++) begin
            if (cmd.scan_init) begin
                low_found_reg[c]  <= 1'b0;
                high_found_reg[c] <= 1'b0;
            end else if (scan_vld_reg && qual[c]) begin
                // low search never takes the top bin, it is the default anyway
                if (!low_found_reg[c] && scan_idx_reg != AW'(BINS - 1)) begin
                    low_found_reg[c] <= 1'b1;
                    low_reg[c]       <= scan_idx_reg;
                end
                high_found_reg[c] <= 1'b1;
                high_reg[c]       <= scan_idx_reg;
            end
            if (cmd.result_load) begin
                low_res_reg[c]  <= low_out[c];
                high_res_reg[c] <= high_out[c];
            end
        end
    end

    assign status.addr_last  = (addr_reg == AW'(BINS - 1));
    assign status.last_pixel = last_reg;

    a_one_port_use: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.pix_read, cmd.pix_write, cmd.sweep}))
        else $error("histogram ports driven by two operations at once");

    a_scan_from_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan_init |=> (addr_reg == '0))
        else $error("bin scan does not start at bin zero");

endmodule

// ===== rtl/hcb_ctrl.sv =====
// controller: clear sweep, pixel read-modify-write, bin scan and result hand-off
module hcb_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    output hcb_pkg::cmd_t    cmd,
    input  hcb_pkg::status_t status
);

    hcb_pkg::state_t state_reg, state_next;
    logic            m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= hcb_pkg::ST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        s_ready      = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            hcb_pkg::ST_CLEAR: begin
                cmd.sweep = 1'b1;
                if (status.addr_last) begin
                    state_next = hcb_pkg::ST_IDLE;
                end
            end
            hcb_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.pix_read = 1'b1;
                    state_next   = hcb_pkg::ST_UPD;
                end
            end
            hcb_pkg::ST_UPD: begin
                cmd.pix_write = 1'b1;
                if (status.last_pixel) begin
                    cmd.scan_init = 1'b1;
                    state_next    = hcb_pkg::ST_SCAN;
                end else begin
                    state_next = hcb_pkg::ST_IDLE;
                end
            end
            hcb_pkg::ST_SCAN: begin
                // each bin is read and zeroed in the same cycle
                cmd.sweep = 1'b1;
                cmd.scan  = 1'b1;
                if (status.addr_last) begin
                    state_next = hcb_pkg::ST_DRAIN;
                end
            end
            hcb_pkg::ST_DRAIN: begin
                state_next = hcb_pkg::ST_OUTPUT;
            end
            hcb_pkg::ST_OUTPUT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.result_load = 1'b1;
                    m_valid_next    = 1'b1;
                    state_next      = hcb_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = hcb_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;

    a_upd_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == hcb_pkg::ST_UPD) |-> $past(state_reg == hcb_pkg::ST_IDLE && s_valid))
        else $error("update without an accepted word");

    a_scan_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == hcb_pkg::ST_SCAN && status.addr_last) |=>
        (state_reg == hcb_pkg::ST_DRAIN))
        else $error("scan overran the last bin");

    a_result_posted: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == hcb_pkg::ST_OUTPUT && (!m_valid_reg || m_ready)) |=> m_valid_reg)
        else $error("finished scan did not post a result word");

endmodule

// ===== rtl/histogram_color_bounds_unit.sv =====
// top level of the histogram color bounds unit
//
//  channel  direction  handshake            payload
//  s_       in         s_valid / s_ready    s_channel_0..2, s_last_pixel
//  m_       out        m_valid / m_ready    m_ch0..2_low, m_ch0..2_high
//  cfg_     in         cfg_wr_en            cfg_wr_data (count threshold)
//
//  a pixel word takes a histogram ram read, then the saturating write back
//  a last-pixel word passes update, scan and drain before its result word is posted:
//  one scan cycle per bin, all three channel rams swept in parallel and zeroed behind
//  after reset the rams are zeroed in a clearing pass during which s_ready is low
//  the result register frees the input side: pixels are taken while a result waits,
//  only posting the next result waits for m_ready
module histogram_color_bounds_unit #(
    parameter int BINS        = 256,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [hcb_pkg::THRESH_W-1:0] cfg_wr_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [hcb_pkg::COMP_W-1:0]   s_channel_0,
    input  logic [hcb_pkg::COMP_W-1:0]   s_channel_1,
    input  logic [hcb_pkg::COMP_W-1:0]   s_channel_2,
    input  logic                         s_last_pixel,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [hcb_pkg::LOW_W-1:0]    m_ch0_low,
    output logic signed [hcb_pkg::HIGH_W-1:0] m_ch0_high,
    output logic [hcb_pkg::LOW_W-1:0]    m_ch1_low,
    output logic signed [hcb_pkg::HIGH_W-1:0] m_ch1_high,
    output logic [hcb_pkg::LOW_W-1:0]    m_ch2_low,
    output logic signed [hcb_pkg::HIGH_W-1:0] m_ch2_high
);

    hcb_pkg::cmd_t    cmd;
    hcb_pkg::status_t status;

    logic [hcb_pkg::COMP_W-1:0] pix      [hcb_pkg::NUM_CH];
    logic [hcb_pkg::LOW_W-1:0]  res_low  [hcb_pkg::NUM_CH];
    logic [hcb_pkg::HIGH_W-1:0] res_high [hcb_pkg::NUM_CH];

    assign pix[0] = s_channel_0;
    assign pix[1] = s_channel_1;
    assign pix[2] = s_channel_2;

    hcb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    hcb_datapath #(
        .BINS        (BINS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .pix         (pix),
        .pix_last    (s_last_pixel),
        .res_low     (res_low),
        .res_high    (res_high)
    );

    assign m_ch0_low  = res_low[0];
    assign m_ch0_high = $signed(res_high[0]);
    assign m_ch1_low  = res_low[1];
    assign m_ch1_high = $signed(res_high[1]);
    assign m_ch2_low  = res_low[2];
    assign m_ch2_high = $signed(res_high[2]);

endmodule

// ===== bench/hcb_checker.sv =====
// checker that mirrors the histogram bounds behavior and compares every result word
`timescale 1ns / 100ps

module hcb_checker #(
    parameter int BINS        = 256,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [hcb_pkg::THRESH_W-1:0]      cfg_wr_data,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  logic [hcb_pkg::COMP_W-1:0]        s_channel_0,
    input  logic [hcb_pkg::COMP_W-1:0]        s_channel_1,
    input  logic [hcb_pkg::COMP_W-1:0]        s_channel_2,
    input  logic                              s_last_pixel,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  logic [hcb_pkg::LOW_W-1:0]         m_ch0_low,
    input  logic signed [hcb_pkg::HIGH_W-1:0] m_ch0_high,
    input  logic [hcb_pkg::LOW_W-1:0]         m_ch1_low,
    input  logic signed [hcb_pkg::HIGH_W-1:0] m_ch1_high,
    input  logic [hcb_pkg::LOW_W-1:0]         m_ch2_low,
    input  logic signed [hcb_pkg::HIGH_W-1:0] m_ch2_high,
    output int                                mismatches,
    output int                                outstanding
);

    localparam logic [COUNT_WIDTH-1:0] COUNT_TOP = '1;

    typedef struct packed {
        logic [hcb_pkg::NUM_CH-1:0][hcb_pkg::LOW_W-1:0]  low;
        logic [hcb_pkg::NUM_CH-1:0][hcb_pkg::HIGH_W-1:0] high;
    } bounds_t;

    logic [COUNT_WIDTH-1:0]       bin_count [hcb_pkg::NUM_CH][BINS];
    logic [hcb_pkg::THRESH_W-1:0] threshold;
    bounds_t                      bounds_q [$];

    always @(posedge aclk) begin
        logic [hcb_pkg::COMP_W-1:0] comp [hcb_pkg::NUM_CH];
        bounds_t want;
        bounds_t got;
        int b;
        int lo;
        int hi;
        if (!aresetn) begin
            threshold = hcb_pkg::THRESH_RESET;
            for (int ch = 0; ch < hcb_pkg::NUM_CH; ch++) begin
                for (int i = 0; i < BINS; i++) bin_count[ch][i] = '0;
            end
            bounds_q.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end else begin
            if (cfg_wr_en) threshold = cfg_wr_data;

            if (s_valid && s_ready) begin
                comp[0] = s_channel_0;
                comp[1] = s_channel_1;
                comp[2] = s_channel_2;
                for (int ch = 0; ch < hcb_pkg::NUM_CH; ch++) begin
                    b = int'(comp[ch]);
                    // values past the last bin land in it
                    if (b >= BINS) b = BINS - 1;
                    if (bin_count[ch][b] != COUNT_TOP) bin_count[ch][b] = bin_count[ch][b] + 1'b1;
                end
                if (s_last_pixel) begin
                    for (int ch = 0; ch < hcb_pkg::NUM_CH; ch++) begin
                        // upward search never tests the top bin
                        lo = 0;
                        while (lo < BINS - 1 && bin_count[ch][lo] < threshold) lo++;
                        hi = BINS - 1;
                        while (hi >= 0 && bin_count[ch][hi] < threshold) hi--;
                        want.low[ch]  = lo[hcb_pkg::LOW_W-1:0];
                        want.high[ch] = hi[hcb_pkg::HIGH_W-1:0];
                        for (int i = 0; i < BINS; i++) bin_count[ch][i] = '0;
                    end
                    bounds_q.insert(bounds_q.size(), want);
                end
            end

            if (m_valid && m_ready) begin
                got.low  = {m_ch2_low, m_ch1_low, m_ch0_low};
                got.high = {m_ch2_high, m_ch1_high, m_ch0_high};
                if (bounds_q.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected result word: low %0d %0d %0d high %0d %0d %0d",
                                 got.low[0], got.low[1], got.low[2],
                                 $signed(got.high[0]), $signed(got.high[1]),
                                 $signed(got.high[2]));
                    mismatches <= mismatches + 1;
                end else begin
                    want = bounds_q.pop_front();
                    if (got !== want) begin
                        if (mismatches < 10)
                            $display({"bounds mismatch: expected low %0d %0d %0d high %0d %0d %0d,",
                                      " got low %0d %0d %0d high %0d %0d %0d"},
                                     want.low[0], want.low[1], want.low[2],
                                     $signed(want.high[0]), $signed(want.high[1]),
                                     $signed(want.high[2]),
                                     got.low[0], got.low[1], got.low[2],
                                     $signed(got.high[0]), $signed(got.high[1]),
                                     $signed(got.high[2]));
                        mismatches <= mismatches + 1;
                    end
                end
            end

            outstanding <= bounds_q.size();
        end
    end

endmodule

// ===== bench/tb_top.sv =====
// top of the histogram color bounds bench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module tb_top;

    localparam int BINS             = 256;
    localparam int COUNT_WIDTH      = 16;
    localparam int CLK_PERIOD       = 10;
    localparam int SETTLE_CYCLES    = BINS + 44;
    localparam int HOLD_CYCLES      = 3000;
    localparam int RANDOM_PER_PHASE = 220;
    localparam int CYCLE_LIMIT      = 2_000_000;

    localparam int TX_IDLE_PCT [4] = '{0, 58, 0, 8};
    localparam int RX_STALL_PCT [4] = '{0, 0, 58, 8};
    localparam logic [hcb_pkg::THRESH_W-1:0] PHASE_THRESH [8] =
        '{16'd2, 16'd1, 16'd3, 16'd0, 16'd4, 16'd6, 16'd2, 16'd3};

    typedef enum int {
        SPREAD,
        CLUSTER,
        EXTREMES,
        EDGE_CLUSTER
    } comp_mode_t;

    logic                              aclk;
    logic                              aresetn;
    logic                              cfg_wr_en;
    logic [hcb_pkg::THRESH_W-1:0]      cfg_wr_data;
    logic                              s_valid;
    logic                              s_ready;
    logic [hcb_pkg::COMP_W-1:0]        s_channel_0;
    logic [hcb_pkg::COMP_W-1:0]        s_channel_1;
    logic [hcb_pkg::COMP_W-1:0]        s_channel_2;
    logic                              s_last_pixel;
    logic                              m_valid;
    logic                              m_ready;
    logic [hcb_pkg::LOW_W-1:0]         m_ch0_low;
    logic signed [hcb_pkg::HIGH_W-1:0] m_ch0_high;
    logic [hcb_pkg::LOW_W-1:0]         m_ch1_low;
    logic signed [hcb_pkg::HIGH_W-1:0] m_ch1_high;
    logic [hcb_pkg::LOW_W-1:0]         m_ch2_low;
    logic signed [hcb_pkg::HIGH_W-1:0] m_ch2_high;

    int   mismatches;
    int   outstanding;
    int   cycle_count = 0;
    int   tx_idle_pct = 0;
    int   rx_stall_pct = 0;
    logic hold_req = 1'b0;
    logic hold_done = 1'b0;

    histogram_color_bounds_unit #(
        .BINS        (BINS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_channel_0  (s_channel_0),
        .s_channel_1  (s_channel_1),
        .s_channel_2  (s_channel_2),
        .s_last_pixel (s_last_pixel),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_ch0_low    (m_ch0_low),
        .m_ch0_high   (m_ch0_high),
        .m_ch1_low    (m_ch1_low),
        .m_ch1_high   (m_ch1_high),
        .m_ch2_low    (m_ch2_low),
        .m_ch2_high   (m_ch2_high)
    );

    hcb_checker #(
        .BINS        (BINS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_channel_0  (s_channel_0),
        .s_channel_1  (s_channel_1),
        .s_channel_2  (s_channel_2),
        .s_last_pixel (s_last_pixel),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_ch0_low    (m_ch0_low),
        .m_ch0_high   (m_ch0_high),
        .m_ch1_low    (m_ch1_low),
        .m_ch1_high   (m_ch1_high),
        .m_ch2_low    (m_ch2_low),
        .m_ch2_high   (m_ch2_high),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    initial aclk = 1'b0;
    always #(CLK_PERIOD / 2) aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // result side: random stalls, plus one long hold-off so the input backs up
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req && !hold_done) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_done = 1'b1;
            end
            m_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    task automatic send_pixel(input logic [hcb_pkg::COMP_W-1:0] c0,
                              input logic [hcb_pkg::COMP_W-1:0] c1,
                              input logic [hcb_pkg::COMP_W-1:0] c2, input logic last);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_channel_0  <= c0;
        s_channel_1  <= c1;
        s_channel_2  <= c2;
        s_last_pixel <= last;
        do @(posedge aclk); while (!s_ready);
    endtask

    // wait for every result word, then let a scan or clearing pass finish
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_threshold(input logic [hcb_pkg::THRESH_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic send_region(input int len);
        comp_mode_t                 mode [hcb_pkg::NUM_CH];
        logic [hcb_pkg::COMP_W-1:0] base [hcb_pkg::NUM_CH];
        logic [hcb_pkg::COMP_W-1:0] px [hcb_pkg::NUM_CH];
        for (int ch = 0; ch < hcb_pkg::NUM_CH; ch++) begin
            mode[ch] = comp_mode_t'($urandom_range(3));
            base[ch] = hcb_pkg::COMP_W'($urandom);
            if (mode[ch] == EDGE_CLUSTER) base[ch] = $urandom_range(1) ? 8'd0 : 8'd252;
        end
        for (int i = 0; i < len; i++) begin
            for (int ch = 0; ch < hcb_pkg::NUM_CH; ch++) begin
                case (mode[ch])
                    SPREAD:   px[ch] = hcb_pkg::COMP_W'($urandom);
                    EXTREMES: px[ch] = $urandom_range(1) ? 8'hFF : 8'h00;
                    default:  px[ch] = base[ch] + 8'($urandom_range(3));
                endcase
            end
            send_pixel(px[0], px[1], px[2], i == len - 1);
        end
    endtask

    initial begin
        int sent;
        int len;
        aresetn      <= 1'b0;
        cfg_wr_en    <= 1'b0;
        cfg_wr_data  <= '0;
        s_valid      <= 1'b0;
        s_channel_0  <= '0;
        s_channel_1  <= '0;
        s_channel_2  <= '0;
        s_last_pixel <= 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset threshold: a lone pixel qualifies nowhere, five equal ones do
        send_pixel(8'h00, 8'hFF, 8'h5A, 1'b1);
        for (int i = 0; i < 5; i++) send_pixel(8'd3, 8'd128, 8'hFF, i == 4);

        // zero threshold: every bin qualifies
        settle();
        write_threshold(16'd0);
        send_pixel(8'hA5, 8'h3C, 8'hC3, 1'b1);

        settle();
        write_threshold(16'd1);
        send_pixel(8'h00, 8'hFF, 8'h55, 1'b0);
        send_pixel(8'hFF, 8'h00, 8'hAA, 1'b0);
        send_pixel(8'h0F, 8'hF0, 8'h33, 1'b1);

        settle();
        write_threshold(16'd2);
        send_pixel(8'd10, 8'd20, 8'd30, 1'b0);
        send_pixel(8'd10, 8'd21, 8'd30, 1'b0);
        send_pixel(8'd200, 8'd20, 8'd31, 1'b0);
        send_pixel(8'd200, 8'd21, 8'd31, 1'b1);

        // short regions against a stuck receiver
        settle();
        write_threshold(16'd1);
        hold_req = 1'b1;
        for (int r = 0; r < 24; r++) send_region($urandom_range(1, 3));
        hold_req = 1'b0;

        // unreachable threshold: low stays at the top bin, high reports none
        settle();
        write_threshold(16'hFFFF);
        for (int i = 0; i < 6; i++)
            send_pixel(8'd7, 8'(i * 40), 8'hFF, i == 5);

        for (int p = 0; p < 8; p++) begin
            settle();
            write_threshold(p == 7 ? 16'($urandom_range(1, 8)) : PHASE_THRESH[p]);
            tx_idle_pct  = TX_IDLE_PCT[p % 4];
            rx_stall_pct = RX_STALL_PCT[p % 4];
            sent = 0;
            while (sent < RANDOM_PER_PHASE) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 30);
                send_region(len);
                sent += len;
            end
        end

        settle();
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/hcb_pkg.sv
rtl/hcb_ram.sv
rtl/hcb_datapath.sv
rtl/hcb_ctrl.sv
rtl/histogram_color_bounds_unit.sv
bench/hcb_checker.sv
bench/tb_top.sv
